// ----- hdl/imhq_pkg.sv -----
// Package with the request, result, command and status types of the indexed min-heap queue.
package imhq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_DUP    = 2'd2,
    ERR_ABSENT = 2'd3
  } err_t;

  typedef struct packed {
    op_t         req_type;
    logic [9:0]  item_index;
    logic [31:0] item_key;
  } req_t;

  typedef struct packed {
    logic [9:0]  top_item;
    logic [31:0] top_key;
    logic        heap_empty;
    logic [10:0] item_count;
    err_t        error_code;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_POP_LAST,
    ST_POP_KEY,
    ST_POP_INIT,
    ST_LOOK,
    ST_RISE_P,
    ST_RISE_K,
    ST_RISE_C,
    ST_SINK_L,
    ST_SINK_LK,
    ST_SINK_RK,
    ST_SINK_C,
    ST_PLACE,
    ST_ROOT_RD,
    ST_ROOT_K,
    ST_ROOT_W
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic reduce;
    logic look_rd;
    logic err_load;
    err_t err_val;
    logic push_init;
    logic upd_init;
    logic pop_rd_root;
    logic pop_rd_last;
    logic pop_rd_key;
    logic pop_init;
    logic rise_rd;
    logic rise_key;
    logic rise_move;
    logic sink_rd_l;
    logic sink_key_l;
    logic sink_key_r;
    logic sink_move;
    logic place;
    logic root_rd;
    logic root_key;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic item_big;
    op_t  op;
    logic queued;
    logic count_zero;
    logic pos_zero;
    logic rise_less;
    logic has_l;
    logic sink_move;
  } stat_t;

endpackage

// ----- hdl/imhq_ctrl.sv -----
// Controller state machine that sequences the heap operations of the indexed min-heap queue.
module imhq_ctrl
  import imhq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.err_val = ERR_NONE;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (st.item_big) begin
          cmd.reduce = 1'b1;
        end else begin
          case (st.op)
            OP_PEEK: state_next = ST_ROOT_RD;
            OP_POP: begin
              if (st.count_zero) begin
                cmd.err_load = 1'b1;
                cmd.err_val = ERR_EMPTY;
                state_next = ST_ROOT_RD;
              end else begin
                cmd.pop_rd_root = 1'b1;
                state_next = ST_POP_LAST;
              end
            end
            default: begin
              cmd.look_rd = 1'b1;
              state_next = ST_LOOK;
            end
          endcase
        end
      end
      ST_POP_LAST: begin
        cmd.pop_rd_last = 1'b1;
        state_next = ST_POP_KEY;
      end
      ST_POP_KEY: begin
        cmd.pop_rd_key = 1'b1;
        state_next = ST_POP_INIT;
      end
      ST_POP_INIT: begin
        cmd.pop_init = 1'b1;
        state_next = ST_SINK_L;
      end
      ST_LOOK: begin
        if (st.op == OP_PUSH) begin
          if (st.queued) begin
            cmd.err_load = 1'b1;
            cmd.err_val = ERR_DUP;
            state_next = ST_ROOT_RD;
          end else begin
            cmd.push_init = 1'b1;
            state_next = ST_RISE_P;
          end
        end else begin
          if (!st.queued) begin
            cmd.err_load = 1'b1;
            cmd.err_val = ERR_ABSENT;
            state_next = ST_ROOT_RD;
          end else begin
            cmd.upd_init = 1'b1;
            state_next = ST_RISE_P;
          end
        end
      end
      ST_RISE_P: begin
        if (st.pos_zero) begin
          state_next = (st.op == OP_PUSH) ? ST_PLACE : ST_SINK_L;
        end else begin
          cmd.rise_rd = 1'b1;
          state_next = ST_RISE_K;
        end
      end
      ST_RISE_K: begin
        cmd.rise_key = 1'b1;
        state_next = ST_RISE_C;
      end
      ST_RISE_C: begin
        if (st.rise_less) begin
          cmd.rise_move = 1'b1;
          state_next = ST_RISE_P;
        end else begin
          state_next = (st.op == OP_PUSH) ? ST_PLACE : ST_SINK_L;
        end
      end
      ST_SINK_L: begin
        if (st.has_l) begin
          cmd.sink_rd_l = 1'b1;
          state_next = ST_SINK_LK;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_SINK_LK: begin
        cmd.sink_key_l = 1'b1;
        state_next = ST_SINK_RK;
      end
      ST_SINK_RK: begin
        cmd.sink_key_r = 1'b1;
        state_next = ST_SINK_C;
      end
      ST_SINK_C: begin
        if (st.sink_move) begin
          cmd.sink_move = 1'b1;
          state_next = ST_SINK_L;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        state_next = ST_ROOT_RD;
      end
      ST_ROOT_RD: begin
        if (st.count_zero) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.root_rd = 1'b1;
          state_next = ST_ROOT_K;
        end
      end
      ST_ROOT_K: begin
        cmd.root_key = 1'b1;
        state_next = ST_ROOT_W;
      end
      ST_ROOT_W: begin
        cmd.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ----- hdl/imhq_dp.sv -----
// Datapath with the heap, position, key and queued-flag memories and the sift registers.
module imhq_dp
  import imhq_pkg::*;
#(
  parameter int MAX_ITEMS = 1024,
  parameter int KEY_BITS  = 32
)
(
  input  logic  clk,
  input  logic  rst,
  input  req_t  request,
  input  cmd_t  cmd,
  output stat_t st,
  output logic  done,
  output res_t  result
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [16:0] MAX_W = 17'(MAX_ITEMS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ITEMS - 1);

  logic [IW-1:0]       heap_mem [MAX_ITEMS];
  logic [IW-1:0]       slot_mem [MAX_ITEMS];
  logic [KEY_BITS-1:0] key_mem  [MAX_ITEMS];
  logic                qd_mem   [MAX_ITEMS];

  logic [IW-1:0]       heap_rd, slot_rd;
  logic [KEY_BITS-1:0] key_rd;
  logic                qd_rd;

  logic [IW-1:0]       clr_cnt;
  logic [CW-1:0]       count;
  logic [9:0]          item_in;
  op_t                 op;
  logic [KEY_BITS-1:0] key_in;
  err_t                err;
  logic [IW-1:0]       pos, ci, oi, li, ri, root_item;
  logic [KEY_BITS-1:0] ck, lk;

  logic [IW-1:0]       item;
  logic [IW-1:0]       parent;
  logic [IW+1:0]       lft, rgt;
  logic                has_r, go_l, go_r;
  logic [KEY_BITS-1:0] bk;

  logic                heap_re, key_re, heap_we, qd_we, qd_wd;
  logic [IW-1:0]       heap_ra, heap_wa, heap_wd, qd_wa;

  assign item   = IW'(item_in);
  assign parent = (pos - 1'b1) >> 1;
  assign lft    = {1'b0, pos, 1'b1};
  assign rgt    = lft + 1'b1;
  assign has_r  = rgt < (IW+2)'(count);
  assign bk     = (lk < ck) ? lk : ck;
  assign go_r   = has_r && (key_rd < bk);
  assign go_l   = (lk < ck) && !go_r;

  always_comb begin
    st.clear_done = (clr_cnt == LAST_IDX);
    st.item_big   = ({7'd0, item_in} >= MAX_W);
    st.op         = op;
    st.queued     = qd_rd;
    st.count_zero = (count == '0);
    st.pos_zero   = (pos == '0);
    st.rise_less  = (ck < key_rd);
    st.has_l      = lft < (IW+2)'(count);
    st.sink_move  = go_l || go_r;
  end

  always_comb begin
    heap_re = cmd.pop_rd_root | cmd.root_rd | cmd.pop_rd_last | cmd.rise_rd |
              cmd.sink_rd_l | (cmd.sink_key_l & has_r);
    heap_ra = '0;
    if (cmd.pop_rd_last) heap_ra = IW'(count - 1'b1);
    else if (cmd.rise_rd) heap_ra = parent;
    else if (cmd.sink_rd_l) heap_ra = lft[IW-1:0];
    else if (cmd.sink_key_l) heap_ra = rgt[IW-1:0];
    key_re = cmd.pop_rd_key | cmd.rise_key | cmd.sink_key_l | (cmd.sink_key_r & has_r) |
             cmd.root_key;
    heap_we = cmd.rise_move | cmd.sink_move | cmd.place;
    heap_wa = pos;
    heap_wd = ci;
    if (cmd.rise_move) heap_wd = oi;
    else if (cmd.sink_move) heap_wd = go_r ? ri : li;
    qd_we = cmd.clr_wr | cmd.push_init | cmd.pop_rd_last;
    qd_wa = clr_cnt;
    qd_wd = 1'b0;
    if (cmd.push_init) begin
      qd_wa = item;
      qd_wd = 1'b1;
    end else if (cmd.pop_rd_last) begin
      qd_wa = heap_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
      slot_mem[heap_wd] <= heap_wa;
    end
    if (heap_re) heap_rd <= heap_mem[heap_ra];
    if (cmd.look_rd) slot_rd <= slot_mem[item];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_init || cmd.upd_init) key_mem[item] <= key_in;
    if (key_re) key_rd <= key_mem[heap_rd];
  end

  always_ff @(posedge clk) begin
    if (qd_we) qd_mem[qd_wa] <= qd_wd;
    if (cmd.look_rd) qd_rd <= qd_mem[item];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.push_init) count <= count + 1'b1;
      else if (cmd.pop_init) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= request.req_type;
      item_in <= request.item_index;
      key_in  <= KEY_BITS'(request.item_key);
      err     <= ERR_NONE;
    end
    if (cmd.reduce) item_in <= item_in - 10'(MAX_ITEMS);
    if (cmd.err_load) err <= cmd.err_val;
    if (cmd.push_init) begin
      ci  <= item;
      ck  <= key_in;
      pos <= IW'(count);
    end
    if (cmd.upd_init) begin
      ci  <= item;
      ck  <= key_in;
      pos <= slot_rd;
    end
    if (cmd.pop_rd_key) ci <= heap_rd;
    if (cmd.pop_init) begin
      ck  <= key_rd;
      pos <= '0;
    end
    if (cmd.rise_key) oi <= heap_rd;
    if (cmd.rise_move) pos <= parent;
    if (cmd.sink_key_l) li <= heap_rd;
    if (cmd.sink_key_r) begin
      lk <= key_rd;
      ri <= heap_rd;
    end
    if (cmd.sink_move) pos <= go_r ? rgt[IW-1:0] : lft[IW-1:0];
    if (cmd.root_key) root_item <= heap_rd;
    if (cmd.emit) begin
      result.heap_empty <= (count == '0);
      result.item_count <= 11'(count);
      result.error_code <= err;
      if (count == '0) begin
        result.top_item <= '0;
        result.top_key  <= '0;
      end else begin
        result.top_item <= 10'(root_item);
        result.top_key  <= 32'(key_rd);
      end
    end
  end

endmodule

// ----- hdl/indexed_min_heap_queue.sv -----
// Top level of the indexed min-heap queue: controller, datapath and checks.
//
//   channel   signals                 direction  handshake
//   request   start, busy, request    in         taken when start and not busy
//   result    done, result            out        one cycle strobe, no stall
//
// A request keeps busy high through setup and readout, plus states RISE_P, RISE_K, RISE_C
// per level compared on the way up and SINK_L, SINK_LK, SINK_RK, SINK_C per level down.
// Each level up reads the heap and key memories once; each level down reads them twice
// if it has a right child, else once. The result shows in the first cycle that busy is low again.
// After reset the queued-flag memory is swept clear, one entry a cycle, while busy is high.
// Results cannot be held off; a new request may be taken in the cycle a result shows.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int MAX_ITEMS = 1024,
  parameter int KEY_BITS  = 32
)
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  cmd_t  cmd;
  stat_t st;

  imhq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  imhq_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .st      (st),
    .done    (done),
    .result  (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.heap_empty |-> result.top_item == '0 && result.top_key == '0)
    else $error("empty queue reported a nonzero top");

endmodule
